// ===== hdl/assert_macros.svh =====
// assert_macros.svh: shorthand forms for the concurrent assertions of the checker.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, with reset masking the check.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Overlapping implication that is also checked during reset.
`define ASSERT_SEQ(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> cons) \
      else $error(msg);

`endif

// ===== hdl/gnf_pkg.sv =====
// gnf_pkg: types, constants and arithmetic helpers of the gradient noise block.
// Used by the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package gnf_pkg;

   localparam int TBL_BITS   = 8;
   localparam int COORD_BITS = 24;
   localparam int VAL_W      = 21;
   localparam int SUM_W      = 32;
   localparam int W_BITS     = 17;
   localparam int NUM_STAGES = 13;
   localparam int MAX_OCT    = 16;
   localparam int NUM_CORNER = 8;

   localparam logic [2:0] FUNC_PERM  = 3'd0;
   localparam logic [2:0] FUNC_GRAD1 = 3'd1;
   localparam logic [2:0] FUNC_GRAD2 = 3'd2;
   localparam logic [2:0] FUNC_GRAD3 = 3'd3;
   localparam logic [2:0] FUNC_EVAL  = 3'd4;

   localparam logic [1:0] CSR_DIMS      = 2'd0;
   localparam logic [1:0] CSR_OCTAVES   = 2'd1;
   localparam logic [1:0] CSR_INV_ALPHA = 2'd2;
   localparam logic [1:0] CSR_BETA      = 2'd3;

   localparam logic [1:0] SEC_1D = 2'd1;
   localparam logic [1:0] SEC_2D = 2'd2;
   localparam logic [1:0] SEC_3D = 2'd3;

   localparam logic [W_BITS-1:0] W_ONE = 17'd65536;
   localparam logic [W_BITS-1:0] W_MAX = 17'd131071;
   localparam logic signed [SUM_W-1:0] OUT_MAX = 32'sd524287;
   localparam logic signed [SUM_W-1:0] OUT_MIN = -32'sd524288;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic signed [15:0]    grad_type;
   typedef logic signed [19:0]    noise_type;

   // One point-octave traveling around the ring.
   typedef struct packed {
      logic [4:0]              oct;
      coord_type               px;
      coord_type               py;
      coord_type               pz;
      logic [W_BITS-1:0]       w;
      logic signed [SUM_W-1:0] sum;
   } tok_type;

   // Point scaled by beta (Q4.12), wrapped to the lattice period.
   function automatic coord_type scale_coord(input coord_type c, input logic [15:0] b);
      logic [39:0] prod;
      prod = {16'd0, c} * {24'd0, b};
      return prod[35:12];
   endfunction

   // Square of a Q.16 fraction, floored back to Q.16.
   function automatic logic [15:0] sq_hi(input logic [15:0] t);
      logic [31:0] prod;
      prod = {16'd0, t} * {16'd0, t};
      return prod[31:16];
   endfunction

   // Fade curve t*t*(3 - 2t) from the precomputed square.
   function automatic logic [16:0] smooth(input logic [15:0] t2, input logic [15:0] t);
      logic [17:0] fac;
      logic [33:0] prod;
      fac  = 18'd196608 - {1'b0, t, 1'b0};
      prod = {18'd0, t2} * {16'd0, fac};
      return prod[32:16];
   endfunction

   function automatic noise_type sat_out(input logic signed [SUM_W-1:0] s);
      if (s > OUT_MAX) return noise_type'(OUT_MAX);
      if (s < OUT_MIN) return noise_type'(OUT_MIN);
      return s[19:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/gnf_ram.sv =====
// gnf_ram: single-write, single-read memory with a registered read port.
// Generic; depends on nothing.
`default_nettype none

module gnf_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [0:(1 << ADDR_BITS)-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/gradient_noise_fractal_sum.sv =====
// gradient_noise_fractal_sum: fractal sum of lattice gradient noise, 13-stage ring.
// Each point passes the 13-stage ring once per octave, octaves clamped to 1..16.
// Throughput: one request per cycle for one octave unless the result side stalls;
// a returning point takes its ring slot first. Table loads wait for an empty ring.
// Sync reset clears valid bits and resets the CSRs, not the data or the tables.
`default_nettype none

module gradient_noise_fractal_sum (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [7:0]          req_table_index,
   input  logic [7:0]          req_perm_value,
   input  gnf_pkg::grad_type   req_grad_x,
   input  gnf_pkg::grad_type   req_grad_y,
   input  gnf_pkg::grad_type   req_grad_z,
   input  gnf_pkg::coord_type  req_coord_x,
   input  gnf_pkg::coord_type  req_coord_y,
   input  gnf_pkg::coord_type  req_coord_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output gnf_pkg::noise_type  rsp_noise_value,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [16:0]         csr_write_data
);

   import gnf_pkg::*;

   // The user must change these registers only while the ring is empty; unchecked.
   logic [1:0]        dims_ff;
   logic [4:0]        octaves_ff;
   logic [16:0]       inv_alpha_ff;
   logic [15:0]       beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= 2'd3;
         octaves_ff   <= 5'd1;
         inv_alpha_ff <= 17'd32768;
         beta_ff      <= 16'd8192;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIMS:      dims_ff      <= csr_write_data[1:0];
            CSR_OCTAVES:   octaves_ff   <= csr_write_data[4:0];
            CSR_INV_ALPHA: inv_alpha_ff <= csr_write_data;
            CSR_BETA:      beta_ff      <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Number of ring passes per point. Zero octaves still takes one pass, and
   // the result is forced to zero at the output.
   logic [4:0] passes;
   always_comb begin
      if (octaves_ff == 5'd0) begin
         passes = 5'd1;
      end else if (octaves_ff > 5'(MAX_OCT)) begin
         passes = 5'(MAX_OCT);
      end else begin
         passes = octaves_ff;
      end
   end

   // Ring control. Every stage moves together; the ring only holds when a
   // finished point meets a result register that is full and stalled.
   logic [NUM_STAGES:1] vld_ff;
   tok_type             tok_ff [1:NUM_STAGES];
   logic                rsp_valid_ff;
   noise_type           rsp_noise_ff;

   logic fin_done, recirc, finish, adv, ring_busy;
   logic req_is_eval, req_is_load, req_take;

   assign fin_done    = (tok_ff[NUM_STAGES].oct >= passes);
   assign recirc      = vld_ff[NUM_STAGES] && !fin_done;
   assign finish      = vld_ff[NUM_STAGES] && fin_done;
   assign adv         = !(rsp_valid_ff && rsp_stall && finish);
   assign ring_busy   = |vld_ff;
   assign req_is_eval = (req_func == FUNC_EVAL);
   assign req_is_load = (req_func == FUNC_PERM) || (req_func == FUNC_GRAD1) ||
                        (req_func == FUNC_GRAD2) || (req_func == FUNC_GRAD3);
   // A returning point owns the ring slot, so new requests wait for it. Loads
   // wait for an empty ring so that no point in flight sees a table change.
   assign req_stall   = !adv || recirc || (req_is_load && ring_busy);
   assign req_take    = req_valid && !req_stall;

   // Ring head: the returning point, a new point, or a bubble.
   logic    head_vld;
   tok_type head_tok;
   always_comb begin
      if (recirc) begin
         head_vld = 1'b1;
         head_tok = tok_ff[NUM_STAGES];
      end else begin
         head_vld     = req_take && req_is_eval;
         head_tok.oct = 5'd0;
         head_tok.px  = req_coord_x;
         head_tok.py  = req_coord_y;
         head_tok.pz  = req_coord_z;
         head_tok.w   = W_ONE;
         head_tok.sum = '0;
      end
   end

   // Tables. The permutation table is kept in six copies and the gradient
   // tables in eight, so each hash and corner read has a port of its own.
   // The three gradient tables share one memory, split by the top address bits.
   logic        perm_we, grad_we;
   logic [9:0]  grad_waddr;
   logic [47:0] grad_wdata;
   logic [7:0]  pa_addr [2];
   logic [7:0]  pa_rd   [2];
   logic [7:0]  h_addr  [4];
   logic [7:0]  h_rd    [4];
   logic [9:0]  g_addr  [NUM_CORNER];
   logic [47:0] g_rd    [NUM_CORNER];

   assign perm_we    = req_take && (req_func == FUNC_PERM);
   assign grad_we    = req_take && ((req_func == FUNC_GRAD1) || (req_func == FUNC_GRAD2) ||
                                    (req_func == FUNC_GRAD3));
   assign grad_waddr = {req_func[1:0], req_table_index};

   // Unused components of the 1D and 2D entries are stored as zero, so one
   // three-term dot product serves every dimension.
   always_comb begin
      case (req_func)
         FUNC_GRAD1: grad_wdata = {32'd0, req_grad_x};
         FUNC_GRAD2: grad_wdata = {16'd0, req_grad_y, req_grad_x};
         default:    grad_wdata = {req_grad_z, req_grad_y, req_grad_x};
      endcase
   end

   assign pa_addr[0] = head_tok.px[23:16];
   assign pa_addr[1] = head_tok.px[23:16] + 8'd1;

   for (genvar gi = 0; gi < 2; gi++) begin : g_perm_a
      gnf_ram #(.WIDTH(8), .ADDR_BITS(TBL_BITS)) u_ram (
         .clock   (clock),
         .wr_en   (perm_we),
         .wr_addr (req_table_index),
         .wr_data (req_perm_value),
         .rd_en   (adv),
         .rd_addr (pa_addr[gi]),
         .rd_data (pa_rd[gi])
      );
   end

   for (genvar gi = 0; gi < 4; gi++) begin : g_perm_b
      gnf_ram #(.WIDTH(8), .ADDR_BITS(TBL_BITS)) u_ram (
         .clock   (clock),
         .wr_en   (perm_we),
         .wr_addr (req_table_index),
         .wr_data (req_perm_value),
         .rd_en   (adv),
         .rd_addr (h_addr[gi]),
         .rd_data (h_rd[gi])
      );
   end

   for (genvar gi = 0; gi < NUM_CORNER; gi++) begin : g_grad
      gnf_ram #(.WIDTH(48), .ADDR_BITS(TBL_BITS + 2)) u_ram (
         .clock   (clock),
         .wr_en   (grad_we),
         .wr_addr (grad_waddr),
         .wr_data (grad_wdata),
         .rd_en   (adv),
         .rd_addr (g_addr[gi]),
         .rd_data (g_rd[gi])
      );
   end

   // Stage 1: cell and fraction per axis, fraction squared, next point.
   logic [15:0] t1_ff [3];
   logic [15:0] q1_ff [3];
   logic [7:0]  yb_1_ff, zb_1_ff;
   // Stage 2: fade values, permutation of the x cell.
   logic [15:0] t2_ff [3];
   logic [16:0] s2_ff [3];
   logic [7:0]  i2_ff, j2_ff, zb_2_ff;
   // Stage 3: gradients arrive from the corner memories.
   logic [15:0] t3_ff [3];
   logic [16:0] s3_ff [3];
   // Stage 4: gradient component products.
   logic signed [33:0] p4_ff [NUM_CORNER][3];
   logic [16:0]        s4_ff [3];
   // Stage 5: corner dot products.
   logic signed [VAL_W-1:0] d5_ff [NUM_CORNER];
   logic [16:0]             s5_ff [3];
   // Stages 6 to 11: interpolation along x, then y, then z.
   logic signed [39:0]      m6_ff [4];
   logic signed [VAL_W-1:0] a6_ff [4];
   logic [16:0]             sy6_ff, sz6_ff;
   logic signed [VAL_W-1:0] x7_ff [4];
   logic [16:0]             sy7_ff, sz7_ff;
   logic signed [39:0]      m8_ff [2];
   logic signed [VAL_W-1:0] a8_ff [2];
   logic [16:0]             sz8_ff;
   logic signed [VAL_W-1:0] c9_ff [2];
   logic signed [VAL_W-1:0] n1_9_ff;
   logic [16:0]             sz9_ff;
   logic signed [39:0]      m10_ff;
   logic signed [VAL_W-1:0] a10_ff, n1_10_ff;
   logic signed [VAL_W-1:0] noise11_ff;
   // Stage 12: noise times octave weight.
   logic signed [38:0]      m12_ff;

   // Combinational logic between the stages.
   coord_type               head_c   [3];
   tok_type                 tok1_in;
   logic [7:0]              yb1_2;
   logic [7:0]              zb_sel;
   logic signed [17:0]      rlo [3];
   logic signed [17:0]      rhi [3];
   logic signed [15:0]      gc;
   logic signed [17:0]      rs;
   logic signed [33:0]      p4_in [NUM_CORNER][3];
   logic signed [35:0]      dsum;
   logic signed [VAL_W-1:0] d5_in [NUM_CORNER];
   logic signed [21:0]      diff;
   logic signed [39:0]      m6_in [4];
   logic [23:0]             lsum;
   logic signed [VAL_W-1:0] x7_in [4];
   logic signed [39:0]      m8_in [2];
   logic signed [VAL_W-1:0] c9_in [2];
   logic signed [39:0]      m10_in;
   logic signed [VAL_W-1:0] noise11_in;
   logic signed [38:0]      m12_in;
   logic [33:0]             wprod;
   tok_type                 tok13_in;

   assign head_c[0] = head_tok.px;
   assign head_c[1] = head_tok.py;
   assign head_c[2] = head_tok.pz;

   // The point for the next octave is formed on the way into the ring.
   always_comb begin
      tok1_in    = head_tok;
      tok1_in.px = scale_coord(head_tok.px, beta_ff);
      tok1_in.py = scale_coord(head_tok.py, beta_ff);
      tok1_in.pz = scale_coord(head_tok.pz, beta_ff);
   end

   // Hash of the x cell with the y cell, for the four xy corners.
   always_comb begin
      yb1_2     = yb_1_ff + 8'd1;
      h_addr[0] = pa_rd[0] + yb_1_ff;
      h_addr[1] = pa_rd[1] + yb_1_ff;
      h_addr[2] = pa_rd[0] + yb1_2;
      h_addr[3] = pa_rd[1] + yb1_2;
   end

   // Corner k has x offset k[0], y offset k[1] and z offset k[2].
   always_comb begin
      for (int k = 0; k < NUM_CORNER; k++) begin
         zb_sel = k[2] ? (zb_2_ff + 8'd1) : zb_2_ff;
         case (dims_ff)
            2'd2:    g_addr[k] = {SEC_2D, h_rd[k % 4]};
            2'd3:    g_addr[k] = {SEC_3D, h_rd[k % 4] + zb_sel};
            default: g_addr[k] = {SEC_1D, k[0] ? j2_ff : i2_ff};
         endcase
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rlo[a] = $signed({2'b00, t3_ff[a]});
         rhi[a] = rlo[a] - 18'sd65536;
      end
      for (int k = 0; k < NUM_CORNER; k++) begin
         for (int c = 0; c < 3; c++) begin
            gc          = g_rd[k][16*c +: 16];
            rs          = k[c] ? rhi[c] : rlo[c];
            p4_in[k][c] = gc * rs;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CORNER; k++) begin
         dsum     = 36'(p4_ff[k][0]) + 36'(p4_ff[k][1]) + 36'(p4_ff[k][2]);
         d5_in[k] = dsum[35:15];
      end
   end

   always_comb begin
      for (int m = 0; m < 4; m++) begin
         diff     = 22'(d5_ff[2*m+1]) - 22'(d5_ff[2*m]);
         m6_in[m] = diff * $signed({1'b0, s5_ff[0]});
      end
      for (int m = 0; m < 4; m++) begin
         lsum     = 24'(a6_ff[m]) + m6_ff[m][39:16];
         x7_in[m] = lsum[VAL_W-1:0];
      end
      for (int m = 0; m < 2; m++) begin
         diff     = 22'(x7_ff[2*m+1]) - 22'(x7_ff[2*m]);
         m8_in[m] = diff * $signed({1'b0, sy7_ff});
      end
      for (int m = 0; m < 2; m++) begin
         lsum     = 24'(a8_ff[m]) + m8_ff[m][39:16];
         c9_in[m] = lsum[VAL_W-1:0];
      end
      diff   = 22'(c9_ff[1]) - 22'(c9_ff[0]);
      m10_in = diff * $signed({1'b0, sz9_ff});
      lsum   = 24'(a10_ff) + m10_ff[39:16];
      case (dims_ff)
         2'd2:    noise11_in = a10_ff;
         2'd3:    noise11_in = lsum[VAL_W-1:0];
         default: noise11_in = n1_10_ff;
      endcase
      m12_in = noise11_ff * $signed({1'b0, tok_ff[11].w});
   end

   // Last stage: accumulate, advance the weight and count the octave.
   always_comb begin
      tok13_in     = tok_ff[12];
      tok13_in.sum = tok_ff[12].sum + SUM_W'($signed(m12_ff[38:16]));
      wprod        = {17'd0, tok_ff[12].w} * {17'd0, inv_alpha_ff};
      tok13_in.w   = (wprod[33:16] > {1'b0, W_MAX}) ? W_MAX : wprod[32:16];
      tok13_in.oct = tok_ff[12].oct + 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-1:1], head_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tok_ff[1] <= tok1_in;
         for (int k = 2; k < NUM_STAGES; k++) begin
            tok_ff[k] <= tok_ff[k-1];
         end
         tok_ff[NUM_STAGES] <= tok13_in;

         for (int a = 0; a < 3; a++) begin
            t1_ff[a] <= head_c[a][15:0];
            q1_ff[a] <= sq_hi(head_c[a][15:0]);
            t2_ff[a] <= t1_ff[a];
            s2_ff[a] <= smooth(q1_ff[a], t1_ff[a]);
            t3_ff[a] <= t2_ff[a];
            s3_ff[a] <= s2_ff[a];
            s4_ff[a] <= s3_ff[a];
            s5_ff[a] <= s4_ff[a];
         end
         yb_1_ff <= head_tok.py[23:16];
         zb_1_ff <= head_tok.pz[23:16];
         i2_ff   <= pa_rd[0];
         j2_ff   <= pa_rd[1];
         zb_2_ff <= zb_1_ff;

         p4_ff <= p4_in;
         d5_ff <= d5_in;

         for (int m = 0; m < 4; m++) begin
            m6_ff[m] <= m6_in[m];
            a6_ff[m] <= d5_ff[2*m];
         end
         sy6_ff <= s5_ff[1];
         sz6_ff <= s5_ff[2];
         x7_ff  <= x7_in;
         sy7_ff <= sy6_ff;
         sz7_ff <= sz6_ff;
         for (int m = 0; m < 2; m++) begin
            m8_ff[m] <= m8_in[m];
            a8_ff[m] <= x7_ff[2*m];
         end
         sz8_ff     <= sz7_ff;
         c9_ff      <= c9_in;
         n1_9_ff    <= a8_ff[0];
         sz9_ff     <= sz8_ff;
         m10_ff     <= m10_in;
         a10_ff     <= c9_ff[0];
         n1_10_ff   <= n1_9_ff;
         noise11_ff <= noise11_in;
         m12_ff     <= m12_in;
      end
   end

   // Result register. It takes a finished point while the previous result
   // is being taken, so the ring need not hold on handoff.
   logic rsp_valid_in;
   assign rsp_valid_in = (finish && adv) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish && adv) begin
         rsp_noise_ff <= (octaves_ff == 5'd0) ? '0 : sat_out(tok_ff[NUM_STAGES].sum);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

endmodule

`default_nettype wire

// ===== hdl/gnf_checker.sv =====
// gnf_checker: port-level assertions on the gradient noise block, bound to its top.
// Depends on gnf_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module gnf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input gnf_pkg::noise_type rsp_noise_value
);

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_noise_value), "stalled response changed")
   `ASSERT_SEQ(a_reset_quiet, clock, reset, ##1 !rsp_valid, "response right after reset")
   `ASSERT_SEQ(a_reset_drain, clock, reset, ##2 !rsp_valid, "response too soon after reset")

endmodule

bind gradient_noise_fractal_sum gnf_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_noise_value (rsp_noise_value)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench: self-checking bench for the gradient noise fractal sum block.
// Needs gnf_pkg and gradient_noise_fractal_sum; an in-bench predictor checks every result.
`timescale 1ns / 100ps

module testbench;
   import gnf_pkg::*;

   // Function codes that the block must ignore.
   localparam logic [2:0] FUNC_RSVD5 = 3'd5;
   localparam logic [2:0] FUNC_RSVD6 = 3'd6;
   localparam logic [2:0] FUNC_RSVD7 = 3'd7;
   localparam int DRAIN_CYCLES = 260;
   localparam int HOLD_CYCLES  = 300;
   localparam longint CYCLE_LIMIT = 2000000;
   // Permutation values are kept to multiples of this step, so only those
   // entries of the 1D and 2D gradient tables can ever be read.
   localparam int PERM_STEP = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = FUNC_PERM;
   logic [7:0]  req_table_index = '0;
   logic [7:0]  req_perm_value = '0;
   grad_type    req_grad_x = '0;
   grad_type    req_grad_y = '0;
   grad_type    req_grad_z = '0;
   coord_type   req_coord_x = '0;
   coord_type   req_coord_y = '0;
   coord_type   req_coord_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   noise_type   rsp_noise_value;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_DIMS;
   logic [16:0] csr_write_data = '0;

   gradient_noise_fractal_sum u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_table_index  (req_table_index),
      .req_perm_value   (req_perm_value),
      .req_grad_x       (req_grad_x),
      .req_grad_y       (req_grad_y),
      .req_grad_z       (req_grad_z),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_noise_value  (rsp_noise_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the tables and the registers.
   // ------------------------------------------------------------------
   logic [7:0]         perm_mem [256];
   logic signed [15:0] grad1_mem [256];
   logic signed [15:0] grad2_mem [256][2];
   logic signed [15:0] grad3_mem [256][3];
   logic [1:0]         cfg_dims;
   logic [4:0]         cfg_octaves;
   logic [16:0]        cfg_inv_alpha;
   logic [15:0]        cfg_beta;

   noise_type expected_noise [$];
   int        error_count = 0;
   bit        idle_enable = 1'b1;
   bit        hold_request = 1'b0;

   typedef struct {
      int     cell0;
      int     cell1;
      longint frac0;
      longint frac1;
      longint fade;
   } lattice_axis_type;

   // Per-axis lattice cell, offsets to both cell corners and the fade weight.
   function automatic lattice_axis_type lattice_axis(input coord_type c);
      lattice_axis_type a;
      longint t, t2;
      a.cell0 = c[23:16];
      a.cell1 = (a.cell0 + 1) & 255;
      t       = c[15:0];
      a.frac0 = t;
      a.frac1 = t - 65536;
      t2      = (t * t) >> 16;
      a.fade  = (t2 * (196608 - 2 * t)) >> 16;
      return a;
   endfunction

   function automatic longint blend(input longint s, input longint a, input longint b);
      return a + ((s * (b - a)) >>> 16);
   endfunction

   function automatic longint dot_plane(input int k, input longint rx, input longint ry);
      return (longint'(grad2_mem[k][0]) * rx + longint'(grad2_mem[k][1]) * ry) >>> 15;
   endfunction

   function automatic longint dot_space(input int k, input longint rx, input longint ry,
                                        input longint rz);
      k = k & 255;
      return (longint'(grad3_mem[k][0]) * rx + longint'(grad3_mem[k][1]) * ry
              + longint'(grad3_mem[k][2]) * rz) >>> 15;
   endfunction

   // Single-octave noise at one point.
   function automatic longint lattice_noise(input coord_type px, input coord_type py,
                                            input coord_type pz);
      lattice_axis_type x, y, z;
      int i, j, h00, h10, h01, h11;
      longint u, v, a, b, c, d;
      x = lattice_axis(px);
      y = lattice_axis(py);
      z = lattice_axis(pz);
      if (cfg_dims <= 2'd1) begin
         u = (longint'(grad1_mem[perm_mem[x.cell0]]) * x.frac0) >>> 15;
         v = (longint'(grad1_mem[perm_mem[x.cell1]]) * x.frac1) >>> 15;
         return blend(x.fade, u, v);
      end
      i   = perm_mem[x.cell0];
      j   = perm_mem[x.cell1];
      h00 = perm_mem[(i + y.cell0) & 255];
      h10 = perm_mem[(j + y.cell0) & 255];
      h01 = perm_mem[(i + y.cell1) & 255];
      h11 = perm_mem[(j + y.cell1) & 255];
      if (cfg_dims == 2'd2) begin
         a = blend(x.fade, dot_plane(h00, x.frac0, y.frac0), dot_plane(h10, x.frac1, y.frac0));
         b = blend(x.fade, dot_plane(h01, x.frac0, y.frac1), dot_plane(h11, x.frac1, y.frac1));
         return blend(y.fade, a, b);
      end
      a = blend(x.fade, dot_space(h00 + z.cell0, x.frac0, y.frac0, z.frac0),
                        dot_space(h10 + z.cell0, x.frac1, y.frac0, z.frac0));
      b = blend(x.fade, dot_space(h01 + z.cell0, x.frac0, y.frac1, z.frac0),
                        dot_space(h11 + z.cell0, x.frac1, y.frac1, z.frac0));
      c = blend(y.fade, a, b);
      a = blend(x.fade, dot_space(h00 + z.cell1, x.frac0, y.frac0, z.frac1),
                        dot_space(h10 + z.cell1, x.frac1, y.frac0, z.frac1));
      b = blend(x.fade, dot_space(h01 + z.cell1, x.frac0, y.frac1, z.frac1),
                        dot_space(h11 + z.cell1, x.frac1, y.frac1, z.frac1));
      d = blend(y.fade, a, b);
      return blend(z.fade, c, d);
   endfunction

   // Weighted octave sum, saturated to the output range.
   function automatic noise_type fractal_sum(input coord_type cx, input coord_type cy,
                                             input coord_type cz);
      longint weight, total, px, py, pz;
      int     count;
      weight = 65536;
      total  = 0;
      px = cx; py = cy; pz = cz;
      count = (cfg_octaves > 5'd16) ? 16 : int'(cfg_octaves);
      for (int k = 0; k < count; k++) begin
         total  += (lattice_noise(coord_type'(px), coord_type'(py), coord_type'(pz))
                    * weight) >>> 16;
         weight  = (weight * longint'(cfg_inv_alpha)) >> 16;
         if (weight > 131071) weight = 131071;
         px = ((px * cfg_beta) >> 12) & 64'hFFFFFF;
         py = ((py * cfg_beta) >> 12) & 64'hFFFFFF;
         pz = ((pz * cfg_beta) >> 12) & 64'hFFFFFF;
      end
      if (total > 524287) total = 524287;
      if (total < -524288) total = -524288;
      return noise_type'(total[19:0]);
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Payload changes only at the falling edge.
   // ------------------------------------------------------------------
   task automatic send_request(input logic [2:0] func, input logic [7:0] index,
                               input logic [7:0] pval, input grad_type gx,
                               input grad_type gy, input grad_type gz,
                               input coord_type cx, input coord_type cy,
                               input coord_type cz);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_table_index <= index;
      req_perm_value  <= pval;
      req_grad_x      <= gx;
      req_grad_y      <= gy;
      req_grad_z      <= gz;
      req_coord_x     <= cx;
      req_coord_y     <= cy;
      req_coord_z     <= cz;
      do @(posedge clock); while (req_stall);
      // Accepted: mirror the effect in the predictor, in request order.
      case (func)
         FUNC_PERM:  perm_mem[index] = pval;
         FUNC_GRAD1: grad1_mem[index] = gx;
         FUNC_GRAD2: begin
            grad2_mem[index][0] = gx;
            grad2_mem[index][1] = gy;
         end
         FUNC_GRAD3: begin
            grad3_mem[index][0] = gx;
            grad3_mem[index][1] = gy;
            grad3_mem[index][2] = gz;
         end
         FUNC_EVAL:  expected_noise.push_back(fractal_sum(cx, cy, cz));
         default: ;
      endcase
   endtask

   // A permutation value from the restricted set.
   function automatic logic [7:0] perm_pick();
      return 8'(PERM_STEP * $urandom_range(0, 256 / PERM_STEP - 1));
   endfunction

   task automatic send_eval(input coord_type cx, input coord_type cy, input coord_type cz);
      send_request(FUNC_EVAL, 8'($urandom), 8'($urandom), grad_type'($urandom),
                   grad_type'($urandom), grad_type'($urandom), cx, cy, cz);
   endtask

   task automatic send_random_load();
      logic [2:0] func;
      func = 3'($urandom_range(0, 3));
      send_request(func, 8'($urandom), perm_pick(), grad_type'($urandom),
                   grad_type'($urandom), grad_type'($urandom),
                   coord_type'($urandom), coord_type'($urandom), coord_type'($urandom));
   endtask

   function automatic coord_type random_coord();
      case ($urandom_range(0, 9))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return {8'($urandom), 16'h0000};
         3:       return {8'($urandom), 16'hFFFF};
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic release_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait until every expected result came back, then let the ring empty.
   task automatic wait_idle();
      release_request();
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [16:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_DIMS:      cfg_dims      = value[1:0];
         CSR_OCTAVES:   cfg_octaves   = value[4:0];
         CSR_INV_ALPHA: cfg_inv_alpha = value;
         CSR_BETA:      cfg_beta      = value[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] dims, input logic [4:0] octs,
                            input logic [16:0] ialpha, input logic [15:0] beta);
      wait_idle();
      write_register(CSR_DIMS, 17'(dims));
      write_register(CSR_OCTAVES, 17'(octs));
      write_register(CSR_INV_ALPHA, ialpha);
      write_register(CSR_BETA, 17'(beta));
   endtask

   // ------------------------------------------------------------------
   // Test tasks.
   // ------------------------------------------------------------------

   // Every table entry that an evaluation can reach is written first. The
   // permutation and 3D tables are filled completely; the 1D and 2D tables
   // only at the permutation values that can occur.
   task automatic test_table_fill();
      for (int k = 0; k < 256; k++) begin
         send_request(FUNC_PERM, k[7:0], perm_pick(), '0, '0, '0, '0, '0, '0);
         send_request(FUNC_GRAD3, k[7:0], '0, grad_type'($urandom), grad_type'($urandom),
                      grad_type'($urandom), '0, '0, '0);
      end
      for (int k = 0; k < 256; k += PERM_STEP) begin
         send_request(FUNC_GRAD1, k[7:0], '0, grad_type'($urandom), '0, '0, '0, '0, '0);
         send_request(FUNC_GRAD2, k[7:0], '0, grad_type'($urandom), grad_type'($urandom),
                      '0, '0, '0, '0);
      end
   endtask

   // Field extremes, ignored function codes and reset-value registers.
   task automatic test_directed();
      send_request(FUNC_PERM, 8'hFF, 8'hF0, '0, '0, '0, '0, '0, '0);
      send_request(FUNC_PERM, 8'h00, 8'h00, '0, '0, '0, '0, '0, '0);
      send_request(FUNC_GRAD1, 8'h00, '0, 16'sh7FFF, '0, '0, '0, '0, '0);
      send_request(FUNC_GRAD2, 8'hFF, '0, -16'sh8000, 16'sh7FFF, '0, '0, '0, '0);
      send_request(FUNC_GRAD3, 8'h00, '0, -16'sh8000, -16'sh8000, -16'sh8000, '0, '0, '0);
      send_request(FUNC_GRAD3, 8'hFF, '0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0, '0, '0);
      // Reserved codes with all-ones, all-zero and mixed payloads must change nothing.
      send_request(FUNC_RSVD5, 8'hFF, 8'hFF, '1, '1, '1, '1, '1, '1);
      send_request(FUNC_RSVD6, 8'h00, 8'h00, '0, '0, '0, '0, '0, '0);
      send_request(FUNC_RSVD7, 8'hA5, 8'h5A, 16'sh1234, '0, '0, '0, '0, '0);
      send_eval(24'h000000, 24'h000000, 24'h000000);
      send_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_eval(24'h00FFFF, 24'hFF0000, 24'h010000);
      send_eval(24'h008000, 24'h7F8000, 24'h808000);
      send_eval(24'hFF0001, 24'h000001, 24'hFFFFFE);
   endtask

   // Corner settings: dimension zero, zero octaves, clamped octave count,
   // saturating weight, zero and maximum scaling.
   task automatic test_register_extremes();
      configure(2'd0, 5'd3, 17'h10000, 16'h2000);
      repeat (4) send_eval(random_coord(), random_coord(), random_coord());
      configure(2'd3, 5'd0, 17'h08000, 16'h2000);
      repeat (3) send_eval(random_coord(), random_coord(), random_coord());
      configure(2'd3, 5'd31, 17'h1FFFF, 16'hFFFF);
      repeat (4) send_eval(random_coord(), random_coord(), random_coord());
      configure(2'd2, 5'd16, 17'h00000, 16'h0000);
      repeat (3) send_eval(random_coord(), random_coord(), random_coord());
      configure(2'd1, 5'd1, 17'h1FFFF, 16'h1000);
      repeat (3) send_eval(random_coord(), random_coord(), random_coord());
   endtask

   // Mixed traffic: mostly evaluations with random points, some table
   // rewrites and a few ignored codes.
   task automatic random_traffic(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 15)
            send_eval(random_coord(), random_coord(), random_coord());
         else if (pick < 19)
            send_random_load();
         else
            send_request(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                         grad_type'($urandom), grad_type'($urandom), grad_type'($urandom),
                         coord_type'($urandom), coord_type'($urandom),
                         coord_type'($urandom));
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 4; phase++) begin
         configure(2'($urandom_range(1, 3)), 5'($urandom_range(1, 4)),
                   17'($urandom_range(0, 131071)), 16'($urandom));
         random_traffic(8);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the ring fills and the block must stall its input.
   task automatic test_backpressure();
      configure(2'd3, 5'd1, 17'h08000, 16'h2000);
      hold_request = 1'b1;
      repeat (30) send_eval(random_coord(), random_coord(), random_coord());
   endtask

   // Closing stretch at full rate, no idling on either side.
   task automatic test_full_rate();
      configure(2'($urandom_range(1, 3)), 5'($urandom_range(1, 2)),
                17'($urandom_range(0, 131071)), 16'($urandom));
      idle_enable = 1'b0;
      random_traffic(24);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts, plus one long hold on request.
   // ------------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_noise.size() == 0) begin
            $error("noise_value: expected none, actual %0d", rsp_noise_value);
            error_count++;
         end else begin
            if (rsp_noise_value !== expected_noise[0]) begin
               $error("noise_value: expected %0d, actual %0d",
                      expected_noise[0], rsp_noise_value);
               error_count++;
            end
            void'(expected_noise.pop_front());
         end
      end
   end

   // Watchdog on the whole run.
   longint cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      // Register values after reset.
      cfg_dims      = 2'd3;
      cfg_octaves   = 5'd1;
      cfg_inv_alpha = 17'd32768;
      cfg_beta      = 16'd8192;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_table_fill();
      test_directed();
      test_register_extremes();
      test_random();
      test_backpressure();
      test_full_rate();

      wait_idle();
      if (expected_noise.size() != 0) begin
         $error("noise_value: %0d results never arrived", expected_noise.size());
         error_count++;
      end
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gnf_pkg.sv
hdl/gnf_ram.sv
hdl/gradient_noise_fractal_sum.sv
hdl/gnf_checker.sv
sim/testbench.sv
